### design/dlt_pkg.sv
// shared types and constants of the dfa longest match tokenizer
// used by dlt_front, dlt_engine and dfa_longest_match_tokenizer; no dependencies
package dlt_pkg;

  localparam int STATE_W        = 8;
  localparam int SYM_W          = 8;
  localparam int TAG_W          = 6;
  localparam int OFFSET_W       = 32;
  localparam int LENGTH_W       = 16;
  localparam int LOOKBACK_DEPTH = 32;
  localparam int IDX_W          = $clog2(LOOKBACK_DEPTH);
  localparam int CNT_W          = $clog2(LOOKBACK_DEPTH + 1);
  localparam int TRANS_ADDR_W   = STATE_W + SYM_W;
  localparam int TRANS_DEPTH    = 1 << TRANS_ADDR_W;
  localparam int FINAL_DEPTH    = 1 << STATE_W;
  localparam int TRANS_W        = STATE_W + 1;
  localparam int FINAL_W        = TAG_W + 1;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_TRANS  = 2'd1,
    KIND_FINAL  = 2'd2,
    KIND_EOI    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_SYMBOL = 4'b0001,
    OP_TRANS  = 4'b0010,
    OP_FINAL  = 4'b0100,
    OP_EOI    = 4'b1000
  } op_t;

  typedef struct packed {
    kind_t              kind;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic               edge_valid;
    logic               is_final;
    logic [TAG_W-1:0]   tag;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [TAG_W-1:0]    token_tag;
    logic [OFFSET_W-1:0] start_offset;
    logic [LENGTH_W-1:0] token_length;
    logic                last;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_out_t;

  typedef struct packed {
    logic pop;
    logic hold;
  } eng_ctl_t;

endpackage

### design/dfa_longest_match_tokenizer.sv
// Table-driven DFA tokenizer with longest match. After reset a clearing pass
// empties the transition and final tables; no input beat is taken during it.
// Beats pass a two-entry queue to the back end, which ends input through the
// EOI and DONE states and scans a symbol through CHECK, SCAN, TRANS and FINAL,
// a registered transition table read followed by the final table read per
// buffered symbol. A failed match rescans the buffered symbols past the accept
// point (at most 31); a full lookback buffer forces such a failure before the
// new symbol is taken. A stalled result holds the back end, but not in EOI.
// depends on dlt_pkg, dlt_front, dlt_engine
module dfa_longest_match_tokenizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dlt_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dlt_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dlt_pkg::STATE_W-1:0] cfg_data
);

  dlt_pkg::q_out_t   q_out;
  dlt_pkg::eng_ctl_t eng_ctl;

  assign cfg_ready = 1'b1;

  dlt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .eng_ctl  (eng_ctl),
    .q_out    (q_out)
  );

  dlt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_out     (q_out),
    .eng_ctl   (eng_ctl),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_hold_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    eng_ctl.hold |-> in_stall) else $error("input taken during clearing");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    eng_ctl.pop |-> q_out.valid) else $error("pop from empty queue");
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.token_tag == '0 && out_data.token_length == 16'd1)
    else $error("malformed error result");
  a_token_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.status |-> out_data.token_length != '0)
    else $error("empty token");
`endif

endmodule

### design/dlt_front.sv
// front end: accepts input beats, decodes the kind and queues them
// depends on dlt_pkg
module dlt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dlt_pkg::in_item_t in_data,
  input  dlt_pkg::eng_ctl_t eng_ctl,
  output dlt_pkg::q_out_t   q_out
);

  dlt_pkg::q_entry_t q_mem_r [2];
  logic [1:0]        count_r, count_nxt;
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic              push;
  logic              pop;
  dlt_pkg::op_t      op;

  always_comb begin
    case (in_data.kind)
      dlt_pkg::KIND_SYMBOL: op = dlt_pkg::OP_SYMBOL;
      dlt_pkg::KIND_TRANS:  op = dlt_pkg::OP_TRANS;
      dlt_pkg::KIND_FINAL:  op = dlt_pkg::OP_FINAL;
      dlt_pkg::KIND_EOI:    op = dlt_pkg::OP_EOI;
      default:              op = dlt_pkg::OP_EOI;
    endcase
  end

  assign in_stall = (count_r == 2'd2) || eng_ctl.hold;
  assign push     = in_valid && !in_stall;
  assign pop      = eng_ctl.pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{op: op, item: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  assign q_out.valid = (count_r != 2'd0);
  assign q_out.entry = q_mem_r[rd_ptr_r];

endmodule

### design/dlt_engine.sv
// back end: transition and final tables, lookback buffer, scan sequencer
// and result register; depends on dlt_pkg
module dlt_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dlt_pkg::q_out_t               q_out,
  output dlt_pkg::eng_ctl_t             eng_ctl,
  input  logic                          cfg_valid,
  input  logic [dlt_pkg::STATE_W-1:0]   cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dlt_pkg::out_item_t            out_data
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_CHECK = 8'b00000100,
    ST_SCAN  = 8'b00001000,
    ST_TRANS = 8'b00010000,
    ST_FINAL = 8'b00100000,
    ST_EOI   = 8'b01000000,
    ST_DONE  = 8'b10000000
  } state_t;

  logic [dlt_pkg::TRANS_W-1:0] trans_mem [dlt_pkg::TRANS_DEPTH];
  logic [dlt_pkg::FINAL_W-1:0] final_mem [dlt_pkg::FINAL_DEPTH];
  logic [dlt_pkg::SYM_W-1:0]   lb_r [dlt_pkg::LOOKBACK_DEPTH];

  state_t                          state_r, state_nxt;
  logic [dlt_pkg::TRANS_ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [dlt_pkg::STATE_W-1:0]     start_state_r, start_state_nxt;
  logic [dlt_pkg::STATE_W-1:0]     cur_state_r, cur_state_nxt;
  logic [dlt_pkg::TAG_W-1:0]       running_tag_r, running_tag_nxt;
  logic [dlt_pkg::OFFSET_W-1:0]    token_start_r, token_start_nxt;
  logic [dlt_pkg::CNT_W-1:0]       token_count_r, token_count_nxt;
  logic [dlt_pkg::CNT_W-1:0]       buf_cnt_r, buf_cnt_nxt;
  logic                            accept_seen_r, accept_seen_nxt;
  logic [dlt_pkg::CNT_W-1:0]       accept_len_r, accept_len_nxt;
  logic [dlt_pkg::TAG_W-1:0]       accept_tag_r, accept_tag_nxt;
  logic                            sym_pend_r, sym_pend_nxt;
  logic [dlt_pkg::SYM_W-1:0]       sym_r, sym_nxt;
  logic                            pend_v_r, pend_v_nxt;
  dlt_pkg::out_item_t              pend_r, pend_nxt;
  logic                            out_valid_r, out_valid_nxt;
  dlt_pkg::out_item_t              out_data_r, out_data_nxt;

  logic [dlt_pkg::TRANS_W-1:0]      trans_rd_r;
  logic [dlt_pkg::FINAL_W-1:0]      final_rd_r;
  logic                             tw_en;
  logic [dlt_pkg::TRANS_ADDR_W-1:0] tw_addr;
  logic [dlt_pkg::TRANS_W-1:0]      tw_data;
  logic                             fw_en;
  logic [dlt_pkg::STATE_W-1:0]      fw_addr;
  logic [dlt_pkg::FINAL_W-1:0]      fw_data;
  logic [dlt_pkg::TRANS_ADDR_W-1:0] tr_addr;
  logic [dlt_pkg::IDX_W-1:0]        rd_idx;
  logic [dlt_pkg::IDX_W-1:0]        wr_idx;
  logic                             lb_we;
  logic                             emit_ok;
  logic                             can_push;
  logic                             gen;
  logic                             fin;
  dlt_pkg::out_item_t               gen_item;
  dlt_pkg::out_item_t               brk_item;
  logic [dlt_pkg::CNT_W-1:0]        brk_k;
  logic                             more;
  logic [dlt_pkg::TAG_W-1:0]        fin_tag;
  dlt_pkg::in_item_t                item;

  assign item     = q_out.entry.item;
  assign rd_idx   = dlt_pkg::IDX_W'(token_start_r[dlt_pkg::IDX_W-1:0]
                    + token_count_r[dlt_pkg::IDX_W-1:0]);
  assign wr_idx   = dlt_pkg::IDX_W'(token_start_r[dlt_pkg::IDX_W-1:0]
                    + buf_cnt_r[dlt_pkg::IDX_W-1:0]);
  assign tr_addr  = {cur_state_r, lb_r[rd_idx]};
  assign emit_ok  = !out_valid_r || !out_stall;
  assign can_push = !pend_v_r || emit_ok;
  assign more     = token_count_r < buf_cnt_r;
  assign fin_tag  = final_rd_r[dlt_pkg::TAG_W-1:0];

  // token at the last accept, or an error on one symbol
  always_comb begin
    brk_item = '0;
    brk_item.start_offset = token_start_r;
    if (accept_seen_r) begin
      brk_item.token_tag    = accept_tag_r;
      brk_item.token_length = dlt_pkg::LENGTH_W'(accept_len_r);
      brk_k                 = accept_len_r;
    end else begin
      brk_item.status       = 1'b1;
      brk_item.token_length = dlt_pkg::LENGTH_W'(1);
      brk_k                 = dlt_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    start_state_nxt = cfg_valid ? cfg_data : start_state_r;
    cur_state_nxt   = cur_state_r;
    running_tag_nxt = running_tag_r;
    token_start_nxt = token_start_r;
    token_count_nxt = token_count_r;
    buf_cnt_nxt     = buf_cnt_r;
    accept_seen_nxt = accept_seen_r;
    accept_len_nxt  = accept_len_r;
    accept_tag_nxt  = accept_tag_r;
    sym_pend_nxt    = sym_pend_r;
    sym_nxt         = sym_r;
    pend_v_nxt      = pend_v_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    eng_ctl.pop     = 1'b0;
    eng_ctl.hold    = (state_r == ST_CLEAR);
    tw_en           = 1'b0;
    tw_addr         = {item.from_state, item.symbol};
    tw_data         = item.edge_valid ? {1'b1, item.to_state} : '0;
    fw_en           = 1'b0;
    fw_addr         = item.from_state;
    fw_data         = {item.is_final, item.tag};
    lb_we           = 1'b0;
    gen             = 1'b0;
    gen_item        = brk_item;
    fin             = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        tw_en       = 1'b1;
        tw_addr     = clr_cnt_r;
        tw_data     = '0;
        fw_en       = 1'b1;
        fw_addr     = clr_cnt_r[dlt_pkg::STATE_W-1:0];
        fw_data     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_out.valid) begin
          eng_ctl.pop = 1'b1;
          case (q_out.entry.op)
            dlt_pkg::OP_SYMBOL: begin
              sym_pend_nxt = 1'b1;
              sym_nxt      = item.symbol;
              state_nxt    = ST_CHECK;
            end
            dlt_pkg::OP_TRANS: tw_en = 1'b1;
            dlt_pkg::OP_FINAL: fw_en = 1'b1;
            dlt_pkg::OP_EOI:   state_nxt = ST_EOI;
            default:           state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        if (!sym_pend_r) begin
          state_nxt = ST_DONE;
        end else if (buf_cnt_r == dlt_pkg::CNT_W'(dlt_pkg::LOOKBACK_DEPTH)) begin
          if (can_push) begin
            gen = 1'b1;
            state_nxt = ST_SCAN;
          end
        end else begin
          lb_we        = 1'b1;
          buf_cnt_nxt  = buf_cnt_r + 1'b1;
          sym_pend_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_nxt = more ? ST_TRANS : ST_CHECK;
      end
      ST_TRANS: begin
        if (trans_rd_r[dlt_pkg::STATE_W]) begin
          cur_state_nxt   = trans_rd_r[dlt_pkg::STATE_W-1:0];
          token_count_nxt = token_count_r + 1'b1;
          state_nxt       = ST_FINAL;
        end else if (can_push) begin
          gen       = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_FINAL: begin
        if (final_rd_r[dlt_pkg::TAG_W]) begin
          accept_seen_nxt = 1'b1;
          accept_len_nxt  = token_count_r;
          if (fin_tag != '0) begin
            running_tag_nxt = fin_tag;
            accept_tag_nxt  = fin_tag;
          end else begin
            accept_tag_nxt  = running_tag_r;
          end
        end
        state_nxt = more ? ST_TRANS : ST_CHECK;
      end
      ST_EOI: begin
        gen             = accept_seen_r;
        token_start_nxt = '0;
        buf_cnt_nxt     = '0;
        cur_state_nxt   = start_state_r;
        running_tag_nxt = '0;
        token_count_nxt = '0;
        accept_seen_nxt = 1'b0;
        accept_len_nxt  = '0;
        accept_tag_nxt  = '0;
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (can_push) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a break consumes the token or one bad symbol and restarts the scan
    if (gen && (state_r != ST_EOI)) begin
      token_start_nxt = token_start_r + dlt_pkg::OFFSET_W'(brk_k);
      buf_cnt_nxt     = buf_cnt_r - brk_k;
      cur_state_nxt   = start_state_r;
      running_tag_nxt = '0;
      token_count_nxt = '0;
      accept_seen_nxt = 1'b0;
      accept_len_nxt  = '0;
      accept_tag_nxt  = '0;
    end

    // one result held back so the last flag is known when it leaves
    if (gen) begin
      if (pend_v_r) begin
        out_valid_nxt     = 1'b1;
        out_data_nxt      = pend_r;
        out_data_nxt.last = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = gen_item;
    end
    if (fin && pend_v_r) begin
      out_valid_nxt     = 1'b1;
      out_data_nxt      = pend_r;
      out_data_nxt.last = 1'b1;
      pend_v_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      trans_mem[tw_addr] <= tw_data;
    end
    trans_rd_r <= trans_mem[tr_addr];
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      final_mem[fw_addr] <= fw_data;
    end
    final_rd_r <= final_mem[trans_rd_r[dlt_pkg::STATE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_r[wr_idx] <= sym_r;
    end
    sym_r      <= sym_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      start_state_r <= '0;
      cur_state_r   <= '0;
      running_tag_r <= '0;
      token_start_r <= '0;
      token_count_r <= '0;
      buf_cnt_r     <= '0;
      accept_seen_r <= 1'b0;
      accept_len_r  <= '0;
      accept_tag_r  <= '0;
      sym_pend_r    <= 1'b0;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      start_state_r <= start_state_nxt;
      cur_state_r   <= cur_state_nxt;
      running_tag_r <= running_tag_nxt;
      token_start_r <= token_start_nxt;
      token_count_r <= token_count_nxt;
      buf_cnt_r     <= buf_cnt_nxt;
      accept_seen_r <= accept_seen_nxt;
      accept_len_r  <= accept_len_nxt;
      accept_tag_r  <= accept_tag_nxt;
      sym_pend_r    <= sym_pend_nxt;
      pend_v_r      <= pend_v_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
